// ===== design/ltp_pkg.sv =====
// Shared constants, types and table functions for the lat/lon to tile pixel projection.
// Used by the channel interfaces, every pipeline cell and the top level; depends on nothing.
package ltp_pkg;

   // Map geometry.
   localparam int TILE_PIXELS = 256;
   localparam int ZOOM_MAX    = 20;
   localparam int TILE_LOG2   = $clog2(TILE_PIXELS);

   // Field widths.
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int ZOOM_W = 5;
   localparam int PIX_W  = 29;

   // Internal datapath widths.
   localparam int V_W    = 34;
   localparam int NORM_W = 32;
   localparam int K_W    = 7;
   localparam int LN_W   = 40;
   localparam int REM_W  = 34;
   localparam int QUO_W  = TILE_LOG2 + ZOOM_MAX + 1;
   localparam int STEP_W = 5;

   // Stage counts.
   localparam int CORDIC_STEPS = 30;
   localparam int HYP_STEPS    = CORDIC_STEPS + 2;
   localparam int NORM_STEPS   = 5;

   // Fixed-point constants (Q30 radians, Q23 degrees, Q32 scale).
   localparam longint Q1          = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint LN2_Q30     = 64'sd744261118;
   localparam longint ATAN1_Q30   = 64'sd843314857;
   localparam longint KINV_Q30    = 64'sd652032874;
   localparam longint DEG2RAD_Q32 = 64'sd74961321;
   localparam longint LAT_LIMIT   = 64'sd713460579;
   localparam longint DEG180_Q23  = 64'sd1509949440;
   localparam longint DEG360_Q23  = 64'sd3019898880;

   // Circular CORDIC vector.
   typedef struct packed {
      logic signed [V_W-1:0] x;
      logic signed [V_W-1:0] y;
      logic signed [V_W-1:0] z;
   } cordic_type;

   // Normalizer word and its power-of-two exponent.
   typedef struct packed {
      logic [NORM_W-1:0]     v;
      logic signed [K_W-1:0] k;
   } norm_type;

   // Hyperbolic CORDIC vector with the exponent carried alongside.
   typedef struct packed {
      logic signed [V_W-1:0] x;
      logic signed [V_W-1:0] y;
      logic signed [V_W-1:0] z;
      logic signed [K_W-1:0] k;
   } hyp_type;

   // Long-division partial remainder and quotient.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   // Per-transaction side data carried next to the datapath.
   typedef struct packed {
      logic [ZOOM_W-1:0] zoom;
      logic              clamped;
      logic              lat_pos;
      logic              lat_neg;
      logic [LON_W-1:0]  u;
   } side_type;

   typedef struct packed {
      logic [ZOOM_W-1:0] zoom;
      logic              clamped;
      logic              lat_pos;
   } tail_type;

   // One result transaction.
   typedef struct packed {
      logic [PIX_W-1:0]  pixel_x;
      logic [PIX_W-1:0]  pixel_y;
      logic [ZOOM_W-1:0] zoom_echo;
      logic              lat_clamped;
   } rsp_type;

   // Shift-subtract division, evaluated only while building the angle tables.
   function automatic longint udiv62(input longint num, input longint den);
      longint quo;
      longint rem;
      quo = 0;
      rem = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'sd1 <<< b);
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in Q30 from its odd power series in Q62.
   function automatic longint atan_q30(input int i);
      longint acc;
      longint term;
      bit     neg;
      acc = 0;
      neg = 1'b0;
      if (i == 0) return ATAN1_Q30;
      for (int k = 1; i * k <= 62; k += 2) begin
         term = udiv62(64'sd1 <<< (62 - i * k), longint'(k));
         acc  = neg ? acc - term : acc + term;
         neg  = !neg;
      end
      return (acc + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // atanh(2^-i) in Q30 from its odd power series in Q62.
   function automatic longint atanh_q30(input int i);
      longint acc;
      acc = 0;
      for (int k = 1; i * k <= 62; k += 2) begin
         acc = acc + udiv62(64'sd1 <<< (62 - i * k), longint'(k));
      end
      return (acc + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // Shift index of each hyperbolic cell; steps 4 and 13 appear twice.
   function automatic int hyp_step(input int c);
      if (c < 4) return c + 1;
      else if (c < 14) return c;
      else return c - 1;
   endfunction

endpackage

// ===== design/ltp_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on ltp_pkg for field widths.
interface ltp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ltp_pkg::LAT_W-1:0]     latitude_deg;
   logic signed [ltp_pkg::LON_W-1:0]     longitude_deg;
   logic [ltp_pkg::ZOOM_W-1:0]           zoom_level;

   modport source (output valid, latitude_deg, longitude_deg, zoom_level, input ready);
   modport sink (input valid, latitude_deg, longitude_deg, zoom_level, output ready);
endinterface

interface ltp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ltp_pkg::PIX_W-1:0]  pixel_x;
   logic [ltp_pkg::PIX_W-1:0]  pixel_y;
   logic [ltp_pkg::ZOOM_W-1:0] zoom_echo;
   logic                       lat_clamped;

   modport source (output valid, pixel_x, pixel_y, zoom_echo, lat_clamped, input ready);
   modport sink (input valid, pixel_x, pixel_y, zoom_echo, lat_clamped, output ready);
endinterface

// ===== design/ltp_rot_cell.sv =====
// One rotation-mode circular CORDIC step, registered.
// Depends on ltp_pkg for the vector type.
module ltp_rot_cell (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [ltp_pkg::STEP_W-1:0]     step,
   input  logic signed [ltp_pkg::V_W-1:0] angle,
   input  ltp_pkg::cordic_type            vec_i,
   output ltp_pkg::cordic_type            vec_o
);

   ltp_pkg::cordic_type vec_ff;
   ltp_pkg::cordic_type vec_in;
   logic signed [ltp_pkg::V_W-1:0] xs;
   logic signed [ltp_pkg::V_W-1:0] ys;

   // Rotate toward zero residual angle.
   always_comb begin
      xs = vec_i.x >>> step;
      ys = vec_i.y >>> step;
      if (!vec_i.z[ltp_pkg::V_W-1]) begin
         vec_in.x = vec_i.x - ys;
         vec_in.y = vec_i.y + xs;
         vec_in.z = vec_i.z - angle;
      end else begin
         vec_in.x = vec_i.x + ys;
         vec_in.y = vec_i.y - xs;
         vec_in.z = vec_i.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) vec_ff <= vec_in;
   end

   assign vec_o = vec_ff;

endmodule

// ===== design/ltp_norm_cell.sv =====
// One stage of the log normalizer: a conditional left shift by a fixed power of two.
// Depends on ltp_pkg for the normalizer type.
module ltp_norm_cell (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [ltp_pkg::STEP_W-1:0] step,
   input  ltp_pkg::norm_type          word_i,
   output ltp_pkg::norm_type          word_o
);

   ltp_pkg::norm_type word_ff;
   ltp_pkg::norm_type word_in;

   // Shift up when the word is small enough that the shift cannot pass bit 30.
   always_comb begin
      word_in = word_i;
      if ((word_i.v >> (ltp_pkg::NORM_W - 1 - int'(step))) == '0) begin
         word_in.v = word_i.v << step;
         word_in.k = word_i.k - ltp_pkg::K_W'(step);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) word_ff <= word_in;
   end

   assign word_o = word_ff;

endmodule

// ===== design/ltp_hyp_cell.sv =====
// One vectoring-mode hyperbolic CORDIC step, registered, with the exponent passed along.
// Depends on ltp_pkg for the vector type.
module ltp_hyp_cell (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [ltp_pkg::STEP_W-1:0]     step,
   input  logic signed [ltp_pkg::V_W-1:0] angle,
   input  ltp_pkg::hyp_type               vec_i,
   output ltp_pkg::hyp_type               vec_o
);

   ltp_pkg::hyp_type vec_ff;
   ltp_pkg::hyp_type vec_in;
   logic signed [ltp_pkg::V_W-1:0] xs;
   logic signed [ltp_pkg::V_W-1:0] ys;

   // Drive y toward zero and accumulate the hyperbolic angle.
   always_comb begin
      xs = vec_i.x >>> step;
      ys = vec_i.y >>> step;
      vec_in.k = vec_i.k;
      if (!vec_i.y[ltp_pkg::V_W-1]) begin
         vec_in.x = vec_i.x - ys;
         vec_in.y = vec_i.y - xs;
         vec_in.z = vec_i.z + angle;
      end else begin
         vec_in.x = vec_i.x + ys;
         vec_in.y = vec_i.y + xs;
         vec_in.z = vec_i.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) vec_ff <= vec_in;
   end

   assign vec_o = vec_ff;

endmodule

// ===== design/ltp_div_cell.sv =====
// One restoring long-division step against a fixed divisor, one quotient bit.
// Depends on ltp_pkg for the division type.
module ltp_div_cell (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [ltp_pkg::REM_W-1:0] divisor,
   input  ltp_pkg::div_type          part_i,
   output ltp_pkg::div_type          part_o
);

   ltp_pkg::div_type part_ff;
   ltp_pkg::div_type part_in;
   logic             bit_q;

   // The remainder stays below twice the divisor, so one compare decides the bit.
   always_comb begin
      bit_q = (part_i.rem >= divisor);
      part_in.rem = (bit_q ? part_i.rem - divisor : part_i.rem) << 1;
      part_in.quo = {part_i.quo[ltp_pkg::QUO_W-2:0], bit_q};
   end

   always_ff @(posedge clock) begin
      if (enable) part_ff <= part_in;
   end

   assign part_o = part_ff;

endmodule

// ===== design/latlon_to_tile_pixel_top.sv =====
// Top level of the Web Mercator lat/lon to world pixel projection pipeline.
// Depends on ltp_pkg, ltp_if and the rotation, normalizer, hyperbolic and divider cells.

// The block takes one transaction per clock while req ready is high and returns one result
// per transaction, in order. Every transaction passes through an input stage, a multiply
// stage, 30 circular CORDIC cells, a log prepare stage, 5 normalizer cells, 32 hyperbolic
// CORDIC cells, a log combine stage, a row stage, 29 long-division cells and the output
// register on its way to the response channel. The whole chain advances together; a
// two-entry output buffer lets it keep accepting while one result waits, and req ready
// drops only when both entries hold results. Latitude beyond the Mercator limit saturates
// the row and raises lat_clamped; zoom above the maximum is saturated.
module latlon_to_tile_pixel_top (
   input logic      clock,
   input logic      reset,
   ltp_req_if.sink   req_if,
   ltp_rsp_if.source rsp_if
);

   localparam int V_W    = ltp_pkg::V_W;
   localparam int ROT_N  = ltp_pkg::CORDIC_STEPS;
   localparam int NORM_N = ltp_pkg::NORM_STEPS;
   localparam int HYP_N  = ltp_pkg::HYP_STEPS;
   localparam int DIV_N  = ltp_pkg::QUO_W;
   localparam int P_PREP = 2 + ROT_N;
   localparam int P_HYP0 = P_PREP + 1 + NORM_N;
   localparam int P_LN   = P_HYP0 + HYP_N;
   localparam int P_T    = P_LN + 1;
   localparam int P_LAST = P_T + DIV_N;

   logic                enable;
   logic [P_LAST:0]     valid_ff;
   ltp_pkg::side_type   side_ff [0:P_T];
   ltp_pkg::side_type   side_in;
   ltp_pkg::tail_type   tail_ff [0:DIV_N-1];
   logic [ltp_pkg::LAT_W-1:0] alat;
   logic [ltp_pkg::LAT_W-1:0] alat_ff;
   logic signed [V_W+1:0]     lon_shift;
   logic [57:0]               phi_prod;
   logic signed [V_W-1:0]     phi_ff;
   logic signed [V_W-1:0]     phi_in;

   ltp_pkg::cordic_type rot_v [0:ROT_N];
   ltp_pkg::norm_type   prep_ff [2];
   ltp_pkg::norm_type   prep_in [2];
   ltp_pkg::norm_type   norm_v  [2][0:NORM_N];
   ltp_pkg::hyp_type    hyp_v   [2][0:HYP_N];
   logic signed [ltp_pkg::LN_W-1:0] ln_ff [2];
   logic signed [ltp_pkg::LN_W-1:0] ln_in [2];
   logic signed [ltp_pkg::LN_W-1:0] g_val;
   logic signed [ltp_pkg::LN_W-1:0] t_raw;
   logic [ltp_pkg::REM_W-1:0]       t_ff;
   logic [ltp_pkg::REM_W-1:0]       t_in;
   ltp_pkg::div_type    div_v [2][0:DIV_N];
   logic [ltp_pkg::REM_W-1:0] divisor [2];

   ltp_pkg::rsp_type    last_rsp;
   ltp_pkg::rsp_type    out_ff;
   ltp_pkg::rsp_type    out_in;
   ltp_pkg::rsp_type    skid_ff;
   ltp_pkg::rsp_type    skid_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   logic                rsp_take;
   logic [ltp_pkg::ZOOM_W-1:0] down_shift;
   logic [ltp_pkg::PIX_W-1:0]  last_world;
   logic [ltp_pkg::PIX_W-1:0]  out_world;

   // Clamp a log argument to at least one and bring it below 2.0 in Q30.
   function automatic ltp_pkg::norm_type log_prep(input logic signed [V_W-1:0] a);
      logic signed [V_W-1:0] c;
      ltp_pkg::norm_type     r;
      c = (a < V_W'(1)) ? V_W'(1) : a;
      if (c >= V_W'(ltp_pkg::Q1 <<< 1)) begin
         r.v = ltp_pkg::NORM_W'(c >>> 1);
         r.k = ltp_pkg::K_W'(1);
      end else begin
         r.v = ltp_pkg::NORM_W'(c);
         r.k = '0;
      end
      return r;
   endfunction

   // The pipeline moves whenever the output buffer has room.
   assign enable       = !skid_valid_ff;
   assign req_if.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[P_LAST-1:0], req_if.valid};
      end
   end

   // Input stage: absolute latitude, Mercator limit, zoom and longitude saturation.
   always_comb begin
      side_in.lat_neg = req_if.latitude_deg[ltp_pkg::LAT_W-1];
      side_in.lat_pos = !side_in.lat_neg && (req_if.latitude_deg != '0);
      alat = side_in.lat_neg ? ltp_pkg::LAT_W'(-req_if.latitude_deg)
                             : ltp_pkg::LAT_W'(req_if.latitude_deg);
      side_in.clamped = (alat > ltp_pkg::LAT_W'(ltp_pkg::LAT_LIMIT));
      side_in.zoom = (req_if.zoom_level > ltp_pkg::ZOOM_W'(ltp_pkg::ZOOM_MAX))
                   ? ltp_pkg::ZOOM_W'(ltp_pkg::ZOOM_MAX) : req_if.zoom_level;
      lon_shift = (V_W+2)'(req_if.longitude_deg) + (V_W+2)'(ltp_pkg::DEG180_Q23);
      if (lon_shift < 0) begin
         side_in.u = '0;
      end else if (lon_shift > (V_W+2)'(ltp_pkg::DEG360_Q23)) begin
         side_in.u = ltp_pkg::LON_W'(ltp_pkg::DEG360_Q23);
      end else begin
         side_in.u = ltp_pkg::LON_W'(lon_shift);
      end
   end

   // Side data shifts along with the datapath.
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         alat_ff    <= alat;
         for (int p = 1; p <= P_T; p++) side_ff[p] <= side_ff[p-1];
         tail_ff[0] <= '{zoom: side_ff[P_T].zoom, clamped: side_ff[P_T].clamped,
                         lat_pos: side_ff[P_T].lat_pos};
         for (int p = 1; p < DIV_N; p++) tail_ff[p] <= tail_ff[p-1];
      end
   end

   // Degrees to Q30 radians, rounded; clamped latitudes start from zero.
   always_comb begin
      phi_prod = {27'd0, alat_ff} * 58'(ltp_pkg::DEG2RAD_Q32);
      phi_in   = side_ff[0].clamped ? '0 : V_W'((phi_prod + 58'd16777216) >> 25);
   end

   always_ff @(posedge clock) begin
      if (enable) phi_ff <= phi_in;
   end

   // Circular CORDIC chain gives cos and sin of the latitude.
   assign rot_v[0] = '{x: V_W'(ltp_pkg::KINV_Q30), y: '0, z: phi_ff};

   for (genvar j = 0; j < ROT_N; j++) begin : g_rot
      localparam logic signed [V_W-1:0] ANG = V_W'(ltp_pkg::atan_q30(j));
      ltp_rot_cell u_cell (
         .clock  (clock),
         .enable (enable),
         .step   (ltp_pkg::STEP_W'(j)),
         .angle  (ANG),
         .vec_i  (rot_v[j]),
         .vec_o  (rot_v[j+1])
      );
   end

   // Log arguments: 1 + sin in lane zero, cos in lane one.
   always_comb begin
      prep_in[0] = log_prep(rot_v[ROT_N].y + V_W'(ltp_pkg::Q1));
      prep_in[1] = log_prep(rot_v[ROT_N].x);
   end

   always_ff @(posedge clock) begin
      if (enable) prep_ff <= prep_in;
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      assign norm_v[l][0] = prep_ff[l];

      // Normalizer brings the argument into [1, 2).
      for (genvar j = 0; j < NORM_N; j++) begin : g_norm
         ltp_norm_cell u_cell (
            .clock  (clock),
            .enable (enable),
            .step   (ltp_pkg::STEP_W'(1 << (NORM_N - 1 - j))),
            .word_i (norm_v[l][j]),
            .word_o (norm_v[l][j+1])
         );
      end

      // Hyperbolic chain computes half the log of the normalized word.
      assign hyp_v[l][0] = '{x: V_W'(norm_v[l][NORM_N].v) + V_W'(ltp_pkg::Q1),
                             y: V_W'(norm_v[l][NORM_N].v) - V_W'(ltp_pkg::Q1),
                             z: '0, k: norm_v[l][NORM_N].k};

      for (genvar j = 0; j < HYP_N; j++) begin : g_hyp
         localparam int STEP = ltp_pkg::hyp_step(j);
         localparam logic signed [V_W-1:0] ANG = V_W'(ltp_pkg::atanh_q30(STEP));
         ltp_hyp_cell u_cell (
            .clock  (clock),
            .enable (enable),
            .step   (ltp_pkg::STEP_W'(STEP)),
            .angle  (ANG),
            .vec_i  (hyp_v[l][j]),
            .vec_o  (hyp_v[l][j+1])
         );
      end

      assign ln_in[l] = (ltp_pkg::LN_W'(hyp_v[l][HYP_N].z) <<< 1)
                      + ltp_pkg::LN_W'(hyp_v[l][HYP_N].k) * ltp_pkg::LN_W'(ltp_pkg::LN2_Q30);

      // Long division: lane zero for the column, lane one for the row.
      for (genvar j = 0; j < DIV_N; j++) begin : g_div
         ltp_div_cell u_cell (
            .clock   (clock),
            .enable  (enable),
            .divisor (divisor[l]),
            .part_i  (div_v[l][j]),
            .part_o  (div_v[l][j+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (enable) ln_ff <= ln_in;
   end

   // Row angle: pi minus the inverse Gudermannian, limited to [0, 2 pi].
   always_comb begin
      g_val = ln_ff[0] - ln_ff[1];
      t_raw = side_ff[P_LN].lat_neg ? ltp_pkg::LN_W'(ltp_pkg::PI_Q30) + g_val
                                    : ltp_pkg::LN_W'(ltp_pkg::PI_Q30) - g_val;
      if (t_raw < 0) begin
         t_in = '0;
      end else if (t_raw > ltp_pkg::LN_W'(ltp_pkg::TWO_PI_Q30)) begin
         t_in = ltp_pkg::REM_W'(ltp_pkg::TWO_PI_Q30);
      end else begin
         t_in = ltp_pkg::REM_W'(t_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) t_ff <= t_in;
   end

   assign divisor[0]  = ltp_pkg::REM_W'(ltp_pkg::DEG360_Q23);
   assign divisor[1]  = ltp_pkg::REM_W'(ltp_pkg::TWO_PI_Q30);
   assign div_v[0][0] = '{rem: ltp_pkg::REM_W'(side_ff[P_T].u), quo: '0};
   assign div_v[1][0] = '{rem: t_ff, quo: '0};

   // Quotients are at the largest zoom; shift down to the requested one.
   always_comb begin
      down_shift = ltp_pkg::ZOOM_W'(ltp_pkg::ZOOM_MAX) - tail_ff[DIV_N-1].zoom;
      last_world = ltp_pkg::PIX_W'(ltp_pkg::TILE_PIXELS) << tail_ff[DIV_N-1].zoom;
      last_rsp.pixel_x     = ltp_pkg::PIX_W'(div_v[0][DIV_N].quo >> down_shift);
      last_rsp.zoom_echo   = tail_ff[DIV_N-1].zoom;
      last_rsp.lat_clamped = tail_ff[DIV_N-1].clamped;
      if (tail_ff[DIV_N-1].clamped) begin
         last_rsp.pixel_y = tail_ff[DIV_N-1].lat_pos ? '0 : last_world;
      end else begin
         last_rsp.pixel_y = ltp_pkg::PIX_W'(div_v[1][DIV_N].quo >> down_shift);
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      rsp_take      = out_valid_ff && rsp_if.ready;
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (valid_ff[P_LAST]) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = last_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = last_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.pixel_x     = out_ff.pixel_x;
   assign rsp_if.pixel_y     = out_ff.pixel_y;
   assign rsp_if.zoom_echo   = out_ff.zoom_echo;
   assign rsp_if.lat_clamped = out_ff.lat_clamped;

   assign out_world = ltp_pkg::PIX_W'(ltp_pkg::TILE_PIXELS) << out_ff.zoom_echo;

   // A held skid entry always sits behind a valid output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without a valid output");

   // A clamped row lies on the top or bottom edge of the world.
   a_clamp_edge: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.lat_clamped) |->
      (out_ff.pixel_y == '0 || out_ff.pixel_y == out_world))
      else $error("clamped latitude row not on a world edge");

   // Results stay inside the world at the echoed zoom.
   a_in_world: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.zoom_echo <= ltp_pkg::ZOOM_W'(ltp_pkg::ZOOM_MAX) &&
                        out_ff.pixel_x <= out_world && out_ff.pixel_y <= out_world))
      else $error("result outside the world pixel range");

endmodule

// ===== sim/latlon_to_tile_pixel_top_tb.sv =====
// Self-checking testbench for the lat/lon to world pixel projection pipeline.
// Depends on ltp_pkg, the ltp_req_if/ltp_rsp_if interfaces and latlon_to_tile_pixel_top.
`timescale 1ns / 100ps

module latlon_to_tile_pixel_top_tb;

   localparam int PIPE_CYCLES = 102;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;

   ltp_req_if req_if ();
   ltp_rsp_if rsp_if ();

   latlon_to_tile_pixel_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ltp_pkg::rsp_type pixel_queue[$];
   int      mismatch_count;
   int      sent_count;
   int      result_count;
   int      clamp_count;
   int      cycle_count;
   bit      idle_enable;

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Arctangent of 2^-i in Q30, from the odd power series in Q62.
   function automatic longint circ_angle(input int i);
      longint acc;
      longint term;
      bit     neg;
      acc = 0;
      neg = 1'b0;
      if (i == 0) return ltp_pkg::ATAN1_Q30;
      for (int k = 1; i * k <= 62; k += 2) begin
         term = (64'sd1 <<< (62 - i * k)) / k;
         acc  = neg ? acc - term : acc + term;
         neg  = !neg;
      end
      return (acc + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // Inverse hyperbolic tangent of 2^-i in Q30.
   function automatic longint hyp_angle(input int i);
      longint acc;
      acc = 0;
      for (int k = 1; i * k <= 62; k += 2) acc = acc + (64'sd1 <<< (62 - i * k)) / k;
      return (acc + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // Natural log in Q30: normalize to [1,2), then hyperbolic vectoring.
   function automatic longint natural_log(input longint v_in);
      longint v, k, x, y, z, xs, ys, a;
      int     reps;
      v = (v_in < 1) ? 64'sd1 : v_in;
      k = 0;
      z = 0;
      while (v < ltp_pkg::Q1) begin
         v = v <<< 1;
         k = k - 1;
      end
      while (v >= 2 * ltp_pkg::Q1) begin
         v = v >>> 1;
         k = k + 1;
      end
      x = v + ltp_pkg::Q1;
      y = v - ltp_pkg::Q1;
      for (int i = 1; i <= 30; i++) begin
         reps = (i == 4 || i == 13) ? 2 : 1;
         a = hyp_angle(i);
         for (int j = 0; j < reps; j++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x - ys; y = y - xs; z = z + a;
            end else begin
               x = x + ys; y = y + xs; z = z - a;
            end
         end
      end
      return 2 * z + k * ltp_pkg::LN2_Q30;
   endfunction

   // Inverse Gudermannian of a Q30 angle via circular rotation and two logs.
   function automatic longint mercator_stretch(input longint phi);
      longint x, y, z, xs, ys, a;
      x = ltp_pkg::KINV_Q30;
      y = 0;
      z = phi;
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         a = circ_angle(i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - a;
         end else begin
            x = x + ys; y = y - xs; z = z + a;
         end
      end
      if (x < 1) x = 1;
      return natural_log(ltp_pkg::Q1 + y) - natural_log(x);
   endfunction

   // Exact floor of a * 2^zoom / den.
   function automatic longint scaled_floor(input longint a, input int zoom, input longint den);
      return ((a / den) <<< zoom) + (((a % den) <<< zoom) / den);
   endfunction

   // Expected world pixel for one request.
   function automatic ltp_pkg::rsp_type project_pixel(
         input logic signed [ltp_pkg::LAT_W-1:0] lat_in,
         input logic signed [ltp_pkg::LON_W-1:0] lon_in,
         input logic [ltp_pkg::ZOOM_W-1:0] zoom_in);
      ltp_pkg::rsp_type res;
      longint  lat, u, alat, world, px, py, phi, g, t;
      int      zoom;
      lat  = lat_in;
      zoom = (zoom_in > ltp_pkg::ZOOM_MAX) ? ltp_pkg::ZOOM_MAX : zoom_in;
      world = longint'(ltp_pkg::TILE_PIXELS) <<< zoom;
      u = longint'(lon_in) + ltp_pkg::DEG180_Q23;
      if (u < 0) u = 0;
      if (u > ltp_pkg::DEG360_Q23) u = ltp_pkg::DEG360_Q23;
      px = scaled_floor(u * ltp_pkg::TILE_PIXELS, zoom, ltp_pkg::DEG360_Q23);
      if (px > world) px = world;
      alat = (lat < 0) ? -lat : lat;
      res.lat_clamped = 1'b0;
      if (alat > ltp_pkg::LAT_LIMIT) begin
         res.lat_clamped = 1'b1;
         py = (lat > 0) ? 0 : world;
      end else begin
         phi = (alat * ltp_pkg::DEG2RAD_Q32 + (64'sd1 <<< 24)) >>> 25;
         g = mercator_stretch(phi);
         t = (lat < 0) ? ltp_pkg::PI_Q30 + g : ltp_pkg::PI_Q30 - g;
         if (t < 0) t = 0;
         if (t > ltp_pkg::TWO_PI_Q30) t = ltp_pkg::TWO_PI_Q30;
         py = scaled_floor(t * ltp_pkg::TILE_PIXELS, zoom, ltp_pkg::TWO_PI_Q30);
         if (py > world) py = world;
      end
      res.pixel_x   = px[ltp_pkg::PIX_W-1:0];
      res.pixel_y   = py[ltp_pkg::PIX_W-1:0];
      res.zoom_echo = zoom[ltp_pkg::ZOOM_W-1:0];
      return res;
   endfunction

   // Send one request transaction, with an optional one-cycle gap before it.
   task automatic send_point(input longint lat, input longint lon, input int zoom);
      if (idle_enable && $urandom_range(0, 99) < 19) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.latitude_deg  <= lat[ltp_pkg::LAT_W-1:0];
      req_if.longitude_deg <= lon[ltp_pkg::LON_W-1:0];
      req_if.zoom_level    <= zoom[ltp_pkg::ZOOM_W-1:0];
      do @(posedge clock); while (!req_if.ready);
      pixel_queue.push_back(project_pixel(lat[ltp_pkg::LAT_W-1:0], lon[ltp_pkg::LON_W-1:0],
                                          zoom[ltp_pkg::ZOOM_W-1:0]));
      sent_count++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
   endtask

   // Response ready toggles at random unless idling is off.
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !(idle_enable && $urandom_range(0, 99) < 16);
   end

   // Compare each accepted result transaction with the oldest prediction.
   always @(posedge clock) begin
      ltp_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count++;
         if (rsp_if.lat_clamped) clamp_count++;
         if (pixel_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result at cycle %0d", cycle_count);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_if.pixel_x !== want.pixel_x || rsp_if.pixel_y !== want.pixel_y ||
                rsp_if.zoom_echo !== want.zoom_echo ||
                rsp_if.lat_clamped !== want.lat_clamped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected x=%0d y=%0d z=%0d c=%0d, got x=%0d y=%0d z=%0d c=%0d",
                           want.pixel_x, want.pixel_y, want.zoom_echo, want.lat_clamped,
                           rsp_if.pixel_x, rsp_if.pixel_y, rsp_if.zoom_echo,
                           rsp_if.lat_clamped);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Corners: field extremes, Mercator limit edges, out-of-range longitude, zoom saturation.
   task automatic test_corners();
      send_point(0, 0, 0);
      send_point(754974720, 1509949440, 20);
      send_point(-754974720, -1509949440, 20);
      send_point(713460579, 0, 20);
      send_point(713460580, 0, 20);
      send_point(-713460579, 0, 20);
      send_point(-713460580, 0, 20);
      send_point(1073741823, 2147483647, 31);
      send_point(-1073741824, -2147483648, 21);
      send_point(1, -1, 1);
      send_point(-1, 1, 19);
      send_point(0, 1509949439, 20);
      send_point(0, -1509949439, 20);
      send_point(335544320, 754974720, 10);
      send_point(-335544320, -754974720, 5);
      send_point(600000000, 1600000000, 24);
      send_point(-600000000, -1600000000, 31);
   endtask

   // Random points: mostly in range, some full-width noise.
   task automatic test_random(input int count);
      longint lat, lon;
      int     zoom;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 8) begin
            lat  = longint'($urandom_range(0, 1509949440)) - 754974720;
            lon  = longint'($urandom_range(0, 32'd3019898880)) - 1509949440;
            zoom = $urandom_range(0, 20);
         end else begin
            lat  = longint'($signed($urandom() & 32'h7FFFFFFF) <<< 1) >>> 1;
            lon  = longint'($signed($urandom()));
            zoom = $urandom_range(0, 31);
         end
         send_point(lat, lon, zoom);
      end
   endtask

   initial begin
      reset                = 1'b1;
      idle_enable          = 1'b1;
      req_if.valid         = 1'b0;
      req_if.latitude_deg  = '0;
      req_if.longitude_deg = '0;
      req_if.zoom_level    = '0;
      rsp_if.ready         = 1'b0;
      mismatch_count = 0;
      sent_count     = 0;
      result_count   = 0;
      clamp_count    = 0;
      cycle_count    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corners();
      test_random(300);
      // Hold off until the pipeline has drained.
      wait_drained();
      idle_enable = 1'b0;
      test_random(250);
      idle_enable = 1'b1;
      test_random(350);

      wait_drained();
      repeat (PIPE_CYCLES + 20) @(posedge clock);
      $display("Sent %0d points, checked %0d results, %0d with clamped latitude.",
               sent_count, result_count, clamp_count);
      $display("Mismatches: %0d.", mismatch_count);
      if (mismatch_count == 0 && pixel_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
